>>> rtl/core/bbr_pkg.sv
// ----------------------------------------------------------------------------
// Box blur RGB332 package
// Frame geometry, datapath widths and the request and response types of the
// shared divider.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int FRAME_WIDTH  = 320;
	localparam int FRAME_HEIGHT = 240;
	localparam int MAX_RADIUS   = 7;

	// Field widths of the ports.
	localparam int POS_X_W  = 9;
	localparam int POS_Y_W  = 8;
	localparam int PIXEL_W  = 8;
	localparam int RADIUS_W = 3;

	// Beat kinds carried on the mode field.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Frame store.
	localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	// Window arithmetic.
	localparam int RAD_W   = $clog2(MAX_RADIUS + 2);
	localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int CNT_N_W = $clog2(WIN_MAX + 1);
	localparam int SUM_W   = $clog2(7 * WIN_MAX + 1);
	// Window coordinates carry a sign bit and one bit of headroom.
	localparam int XS_W    = POS_X_W + 2;
	localparam int YS_W    = POS_Y_W + 2;

	// Divider iteration count width.
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	// Colour channel codes for the division sequence.
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic               start;
		logic [SUM_W-1:0]   dividend;
		logic [CNT_N_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/core/bbr_frame_ram.sv
// ----------------------------------------------------------------------------
// Box blur frame store
// Single write port, single read port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bbr_frame_ram (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [bbr_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [bbr_pkg::PIXEL_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [bbr_pkg::ADDR_W-1:0]  rd_addr,
	output logic [bbr_pkg::PIXEL_W-1:0] rd_data
);

	logic [bbr_pkg::PIXEL_W-1:0] mem [bbr_pkg::DEPTH];
	logic [bbr_pkg::PIXEL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/bbr_div.sv
// ----------------------------------------------------------------------------
// Box blur divider
// Restoring divider, one quotient bit per cycle, shared by the three channels.
// ----------------------------------------------------------------------------
module bbr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bbr_pkg::div_req_t req,
	output bbr_pkg::div_rsp_t rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [bbr_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [bbr_pkg::CNT_N_W-1:0]       rem_q;
	logic [bbr_pkg::SUM_W-1:0]         quo_q;
	logic [bbr_pkg::CNT_N_W-1:0]       dvs_q;
	logic [bbr_pkg::CNT_N_W:0]         trial;
	logic                              fits;

	// The remainder stays below the divisor, so it always fits in the
	// divisor's width.
	assign trial = {rem_q, quo_q[bbr_pkg::SUM_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == bbr_pkg::DIV_CNT_W'(bbr_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? bbr_pkg::CNT_N_W'(trial - {1'b0, dvs_q})
				: trial[bbr_pkg::CNT_N_W-1:0];
			quo_q <= {quo_q[bbr_pkg::SUM_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/core/box_blur_rgb332.sv
// ----------------------------------------------------------------------------
// Box blur RGB332
// Frame store of RGB332 pixels with a per-channel box-blur query.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  input     in_valid/in_stall   mode, pos_x, pos_y, pixel_in
//  output    out_valid/out_stall blurred_pixel
//  config    cfg_wr_en           cfg_wr_data (blur_radius)
//
// A load beat does not stall the input. A query beat stalls the input while
// it walks the window through the frame store read port, waits for the last
// read, runs the shared divider once per channel and loads the output register.
// Reset sets the radius to 1; the frame store is not cleared and needs no pass.
// A finished result waits in the output register while loads are still taken;
// the next query holds at its end until that register is free.
// ----------------------------------------------------------------------------
module box_blur_rgb332 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bbr_pkg::RADIUS_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [bbr_pkg::POS_X_W-1:0]  pos_x,
	input  logic [bbr_pkg::POS_Y_W-1:0]  pos_y,
	input  logic [bbr_pkg::PIXEL_W-1:0]  pixel_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bbr_pkg::PIXEL_W-1:0]  blurred_pixel
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [bbr_pkg::RADIUS_W-1:0]  blur_radius_q;
	logic [bbr_pkg::RAD_W-1:0]     rad;
	logic                          in_acc;
	logic                          ld_inside;

	logic [bbr_pkg::XS_W-1:0]      wx_q, x_lo_q, x_hi_q;
	logic [bbr_pkg::YS_W-1:0]      wy_q, y_hi_q;
	logic                          w_inside;
	logic                          rd_pend_s1;
	logic [1:0]                    ch_q;

	logic [bbr_pkg::SUM_W-1:0]     sum_r_q, sum_g_q, sum_b_q;
	logic [bbr_pkg::CNT_N_W-1:0]   n_q;
	logic [2:0]                    q_r_q, q_g_q;
	logic [1:0]                    q_b_q;
	logic                          out_valid_q;
	logic [bbr_pkg::PIXEL_W-1:0]   out_pixel_q;
	logic                          out_load;

	logic [bbr_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
	logic [bbr_pkg::PIXEL_W-1:0]   rd_data;
	bbr_pkg::div_req_t             div_req;
	bbr_pkg::div_rsp_t             div_rsp;

	assign rad = (bbr_pkg::RAD_W'(blur_radius_q) > bbr_pkg::RAD_W'(bbr_pkg::MAX_RADIUS))
		? bbr_pkg::RAD_W'(bbr_pkg::MAX_RADIUS) : bbr_pkg::RAD_W'(blur_radius_q);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign ld_inside = (bbr_pkg::XS_W'(pos_x) < bbr_pkg::XS_W'(bbr_pkg::FRAME_WIDTH)) &&
		(bbr_pkg::YS_W'(pos_y) < bbr_pkg::YS_W'(bbr_pkg::FRAME_HEIGHT));
	assign wr_addr = bbr_pkg::ADDR_W'(bbr_pkg::ADDR_W'(pos_y) *
		bbr_pkg::ADDR_W'(bbr_pkg::FRAME_WIDTH) + bbr_pkg::ADDR_W'(pos_x));

	// A window coordinate is inside when its sign bit is clear and it is
	// below the frame size.
	assign w_inside = !wx_q[bbr_pkg::XS_W-1] && !wy_q[bbr_pkg::YS_W-1] &&
		(wx_q < bbr_pkg::XS_W'(bbr_pkg::FRAME_WIDTH)) &&
		(wy_q < bbr_pkg::YS_W'(bbr_pkg::FRAME_HEIGHT));
	assign rd_addr = bbr_pkg::ADDR_W'(bbr_pkg::ADDR_W'(wy_q) *
		bbr_pkg::ADDR_W'(bbr_pkg::FRAME_WIDTH) + bbr_pkg::ADDR_W'(wx_q));

	bbr_frame_ram u_ram (
		.clk     (clk),
		.wr_en   (in_acc && (mode == bbr_pkg::MODE_LOAD) && ld_inside),
		.wr_addr (wr_addr),
		.wr_data (pixel_in),
		.rd_en   ((state_q == ST_SCAN) && w_inside),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		div_req.start   = (state_q == ST_DIV_GO);
		div_req.divisor = n_q;
		case (ch_q)
			bbr_pkg::CH_RED:   div_req.dividend = sum_r_q;
			bbr_pkg::CH_GREEN: div_req.dividend = sum_g_q;
			bbr_pkg::CH_BLUE:  div_req.dividend = sum_b_q;
			default:           div_req.dividend = '0;
		endcase
	end

	bbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			blur_radius_q <= bbr_pkg::RADIUS_W'(1);
			rd_pend_s1    <= 1'b0;
			ch_q          <= bbr_pkg::CH_RED;
			out_valid_q   <= 1'b0;
			out_pixel_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				blur_radius_q <= cfg_wr_data;
			end
			rd_pend_s1 <= (state_q == ST_SCAN) && w_inside;
			if (out_load) begin
				out_valid_q <= 1'b1;
				// An empty window gives black.
				out_pixel_q <= (n_q == '0) ? '0 : {q_r_q, q_g_q, q_b_q};
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (mode == bbr_pkg::MODE_QUERY)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (wx_q == x_hi_q && wy_q == y_hi_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					ch_q    <= bbr_pkg::CH_RED;
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (ch_q == bbr_pkg::CH_BLUE) begin
							state_q <= ST_DONE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window walk, accumulation and quotient capture.
	always_ff @(posedge clk) begin
		if (in_acc && (mode == bbr_pkg::MODE_QUERY)) begin
			x_lo_q  <= bbr_pkg::XS_W'(pos_x) - bbr_pkg::XS_W'(rad);
			x_hi_q  <= bbr_pkg::XS_W'(pos_x) + bbr_pkg::XS_W'(rad);
			y_hi_q  <= bbr_pkg::YS_W'(pos_y) + bbr_pkg::YS_W'(rad);
			wx_q    <= bbr_pkg::XS_W'(pos_x) - bbr_pkg::XS_W'(rad);
			wy_q    <= bbr_pkg::YS_W'(pos_y) - bbr_pkg::YS_W'(rad);
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			n_q     <= '0;
		end else begin
			if (state_q == ST_SCAN) begin
				if (wx_q == x_hi_q) begin
					wx_q <= x_lo_q;
					wy_q <= wy_q + 1'b1;
				end else begin
					wx_q <= wx_q + 1'b1;
				end
			end
			if (rd_pend_s1) begin
				sum_r_q <= sum_r_q + bbr_pkg::SUM_W'(rd_data[7:5]);
				sum_g_q <= sum_g_q + bbr_pkg::SUM_W'(rd_data[4:2]);
				sum_b_q <= sum_b_q + bbr_pkg::SUM_W'(rd_data[1:0]);
				n_q     <= n_q + 1'b1;
			end
		end
		if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			case (ch_q)
				bbr_pkg::CH_RED:   q_r_q <= div_rsp.quotient[2:0];
				bbr_pkg::CH_GREEN: q_g_q <= div_rsp.quotient[2:0];
				bbr_pkg::CH_BLUE:  q_b_q <= div_rsp.quotient[1:0];
				default:           q_r_q <= q_r_q;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign blurred_pixel = out_pixel_q;

endmodule
